>>> design/hpp_pkg.sv
// Shared types, codes and constants for the hash table probe block.
package hpp_pkg;

    localparam int CFG_CAP_BITS   = 11;
    localparam int CFG_POWER_BITS = 2;
    localparam logic [CFG_CAP_BITS-1:0]   CAP_RESET   = 11'd1024;
    localparam logic [CFG_POWER_BITS-1:0] POWER_RESET = 2'd2;

    localparam logic [0:0] REG_CAPACITY = 1'b0;
    localparam logic [0:0] REG_POWER    = 1'b1;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY_KEY = 2'd3;

    localparam logic [31:0] HASH_A_INIT = 32'd63689;
    localparam logic [31:0] HASH_A_MUL  = 32'd378551;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_MOD,
        F_PUSH
    } hpp_front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CHECK,
        B_DONE
    } hpp_back_state_t;

endpackage

>>> design/hpp_ram.sv
// Generic simple dual-port RAM with registered read.
module hpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

>>> design/hpp_fifo.sv
// Two-entry queue between the front and back parts.
module hpp_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> design/hpp_front.sv
// Front part: classify the request, hash the key and reduce it to a home slot.
module hpp_front
    import hpp_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BYTES   = 8,
    parameter int VALUE_BITS  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] cap,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       opcode,
    input  logic [63:0]                      key_bytes,
    input  logic [3:0]                       key_length,
    input  logic [31:0]                      value_in,
    output logic                             job_valid,
    input  logic                             job_ready,
    output logic [1:0]                       job_op,
    output logic [KEY_BYTES*8-1:0]           job_key,
    output logic [3:0]                       job_len,
    output logic [VALUE_BITS-1:0]            job_value,
    output logic [$clog2(TABLE_DEPTH)-1:0]   job_home
);

    localparam int KEYW = KEY_BYTES * 8;
    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam logic [3:0] KEY_BYTES_L = 4'(KEY_BYTES);

    hpp_front_state_t state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [KEYW-1:0]  key_reg, key_next, sh_reg, sh_next;
    logic [3:0]       len_reg, len_next, cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [31:0]      h_reg, h_next, a_reg, a_next, div_reg, div_next;
    logic [CW-1:0]    rem_reg, rem_next;
    logic [4:0]       bit_reg, bit_next;

    logic [3:0]       len_c;
    logic [KEYW-1:0]  key_m;
    logic [31:0]      chr;
    logic [CW:0]      trial;

    always_comb
    begin
        len_c = (key_length > KEY_BYTES_L) ? KEY_BYTES_L : key_length;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            key_m[8*b +: 8] = (4'(b) < len_c) ? key_bytes[8*b +: 8] : 8'd0;
        end
    end

    assign chr   = {{24{sh_reg[7]}}, sh_reg[7:0]};
    assign trial = {rem_reg, div_reg[31]};

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        sh_next    = sh_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        h_next     = h_reg;
        a_next     = a_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        in_ready   = 1'b0;
        job_valid  = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next  = opcode;
                    key_next = key_m;
                    sh_next  = key_m;
                    len_next = len_c;
                    val_next = VALUE_BITS'(value_in);
                    h_next   = 32'd0;
                    a_next   = HASH_A_INIT;
                    cnt_next = 4'd0;
                    rem_next = '0;
                    // no probe walk follows for these, so skip the hash
                    if (len_c == 4'd0 || opcode == 2'd3)
                    begin
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        state_next = F_HASH;
                    end
                end
            end
            F_HASH:
            begin
                if (cnt_reg == len_reg)
                begin
                    div_next   = h_reg;
                    rem_next   = '0;
                    bit_next   = 5'd0;
                    state_next = F_MOD;
                end
                else
                begin
                    h_next   = h_reg * a_reg + chr;
                    a_next   = a_reg * HASH_A_MUL;
                    sh_next  = sh_reg >> 8;
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            F_MOD:
            begin
                // restoring remainder, one dividend bit per cycle
                if (trial >= (CW+1)'(cap))
                begin
                    rem_next = CW'(trial - (CW+1)'(cap));
                end
                else
                begin
                    rem_next = CW'(trial);
                end
                div_next = div_reg << 1;
                bit_next = bit_reg + 5'd1;
                if (bit_reg == 5'd31)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                job_valid = 1'b1;
                if (job_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign job_op    = op_reg;
    assign job_key   = key_reg;
    assign job_len   = len_reg;
    assign job_value = val_reg;
    assign job_home  = IW'(rem_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        sh_reg  <= sh_next;
        len_reg <= len_next;
        cnt_reg <= cnt_next;
        val_reg <= val_next;
        h_reg   <= h_next;
        a_reg   <= a_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        bit_reg <= bit_next;
    end

endmodule

>>> design/hpp_back.sv
// Back part: probe walk over the slot store, updates and result register.
module hpp_back
    import hpp_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BYTES   = 8,
    parameter int VALUE_BITS  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] cap,
    input  logic [CFG_POWER_BITS-1:0]        power,
    input  logic                             job_valid,
    output logic                             job_ready,
    input  logic [1:0]                       job_op,
    input  logic [KEY_BYTES*8-1:0]           job_key,
    input  logic [3:0]                       job_len,
    input  logic [VALUE_BITS-1:0]            job_value,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   job_home,
    output logic                             res_valid,
    input  logic                             res_ready,
    output logic [1:0]                       res_status,
    output logic [31:0]                      res_value,
    output logic [9:0]                       res_slot,
    output logic                             clearing
);

    localparam int KEYW = KEY_BYTES * 8;
    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int WW   = KEYW + 5 + VALUE_BITS;
    localparam int LEN_LO  = KEYW;
    localparam int TOMB_B  = KEYW + 4;
    localparam int VAL_LO  = KEYW + 5;

    function automatic logic [IW-1:0] madd(input logic [IW-1:0] x, input logic [IW-1:0] y,
                                           input logic [CW-1:0] c);
        logic [SW-1:0] s;
        begin
            s = SW'(x) + SW'(y);
            if (s >= SW'(c))
            begin
                s = s - SW'(c);
            end
            madd = IW'(s);
        end
    endfunction

    hpp_back_state_t state_reg, state_next;
    logic [IW-1:0]   clr_reg, clr_next;
    logic [1:0]      op_reg, op_next;
    logic [KEYW-1:0] key_reg, key_next;
    logic [3:0]      len_reg, len_next;
    logic [VALUE_BITS-1:0] val_reg, val_next, vout_reg, vout_next;
    logic [IW-1:0]   home_reg, home_next, slot_reg, slot_next;
    logic [CW-1:0]   k_reg, k_next, count_reg, count_next;
    logic [IW-1:0]   f_reg, f_next, d1_reg, d1_next, d2_reg, d2_next, d3_reg, d3_next;
    logic [1:0]      st_reg, st_next;
    logic            out_valid_reg, out_valid_next;
    logic [1:0]      out_status_reg, out_status_next;
    logic [31:0]     out_value_reg, out_value_next;
    logic [9:0]      out_slot_reg, out_slot_next;

    logic [IW-1:0]   one_c, two_c, six_c, off, addr;
    logic            we;
    logic [WW-1:0]   wdata, rdata;
    logic [KEYW-1:0] rd_key;
    logic [3:0]      rd_len;
    logic            rd_tomb;
    logic [VALUE_BITS-1:0] rd_val;

    // small residues of the finite-difference constants
    always_comb
    begin
        one_c = (cap == CW'(1)) ? '0 : IW'(1);
        two_c = (cap > CW'(2)) ? IW'(2) : '0;
        if (cap >= CW'(7))
        begin
            six_c = IW'(6);
        end
        else if (cap == CW'(4))
        begin
            six_c = IW'(2);
        end
        else if (cap == CW'(5))
        begin
            six_c = IW'(1);
        end
        else
        begin
            six_c = '0;
        end
    end

    assign off  = (power == 2'd0) ? ((k_reg == '0) ? '0 : one_c) : f_reg;
    assign addr = madd(home_reg, off, cap);

    assign rd_key  = rdata[KEYW-1:0];
    assign rd_len  = rdata[LEN_LO +: 4];
    assign rd_tomb = rdata[TOMB_B];
    assign rd_val  = rdata[VAL_LO +: VALUE_BITS];

    hpp_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr ((state_reg == B_CLEAR) ? clr_reg : slot_reg),
        .wdata (wdata),
        .raddr (addr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        val_next        = val_reg;
        vout_next       = vout_reg;
        home_next       = home_reg;
        slot_next       = slot_reg;
        k_next          = k_reg;
        count_next      = count_reg;
        f_next          = f_reg;
        d1_next         = d1_reg;
        d2_next         = d2_reg;
        d3_next         = d3_reg;
        st_next         = st_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_slot_next   = out_slot_reg;
        job_ready       = 1'b0;
        we              = 1'b0;
        wdata           = '0;
        case (state_reg)
            B_CLEAR:
            begin
                we       = 1'b1;
                clr_next = clr_reg + IW'(1);
                if (clr_reg == IW'(TABLE_DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    op_next   = job_op;
                    key_next  = job_key;
                    len_next  = job_len;
                    val_next  = job_value;
                    home_next = job_home;
                    vout_next = '0;
                    k_next    = '0;
                    f_next    = '0;
                    d1_next   = one_c;
                    d2_next   = (power == 2'd2) ? two_c : ((power == 2'd3) ? six_c : '0);
                    d3_next   = (power == 2'd3) ? six_c : '0;
                    state_next = B_READ;
                    if (job_len == 4'd0)
                    begin
                        st_next    = ST_EMPTY_KEY;
                        state_next = B_DONE;
                    end
                    else
                    begin
                        case (job_op)
                            OP_INSERT:
                            begin
                                if (count_reg >= cap)
                                begin
                                    st_next    = ST_FULL;
                                    state_next = B_DONE;
                                end
                            end
                            OP_ERASE, OP_FIND:
                            begin
                                state_next = B_READ;
                            end
                            default:
                            begin
                                st_next    = ST_NOT_FOUND;
                                state_next = B_DONE;
                            end
                        endcase
                    end
                end
            end
            B_READ:
            begin
                slot_next  = addr;
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                if (op_reg == OP_INSERT && rd_len == 4'd0)
                begin
                    we         = 1'b1;
                    wdata      = {val_reg, 1'b0, len_reg, key_reg};
                    count_next = count_reg + CW'(1);
                    st_next    = ST_OK;
                    state_next = B_DONE;
                end
                else if (op_reg != OP_INSERT && rd_len == len_reg && rd_key == key_reg)
                begin
                    if (op_reg == OP_ERASE)
                    begin
                        // leave a tombstone so later probes walk past
                        we    = 1'b1;
                        wdata = {rd_val, 1'b1, 4'd0, rd_key};
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    else
                    begin
                        vout_next = rd_val;
                    end
                    st_next    = ST_OK;
                    state_next = B_DONE;
                end
                else if (op_reg != OP_INSERT && rd_len == 4'd0 && !rd_tomb)
                begin
                    st_next    = ST_NOT_FOUND;
                    state_next = B_DONE;
                end
                else if (k_reg == cap)
                begin
                    st_next    = (op_reg == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    state_next = B_DONE;
                end
                else
                begin
                    k_next     = k_reg + CW'(1);
                    f_next     = madd(f_reg, d1_reg, cap);
                    d1_next    = madd(d1_reg, d2_reg, cap);
                    d2_next    = madd(d2_reg, d3_reg, cap);
                    state_next = B_READ;
                end
            end
            B_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_value_next  = (st_reg == ST_OK) ? 32'(vout_reg) : 32'd0;
                    out_slot_next   = (st_reg == ST_OK) ? 10'(slot_reg) : 10'd0;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign res_valid  = out_valid_reg;
    assign res_status = out_status_reg;
    assign res_value  = out_value_reg;
    assign res_slot   = out_slot_reg;
    assign clearing   = (state_reg == B_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        len_reg        <= len_next;
        val_reg        <= val_next;
        vout_reg       <= vout_next;
        home_reg       <= home_next;
        slot_reg       <= slot_next;
        k_reg          <= k_next;
        f_reg          <= f_next;
        d1_reg         <= d1_next;
        d2_reg         <= d2_next;
        d3_reg         <= d3_next;
        st_reg         <= st_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_slot_reg   <= out_slot_next;
    end

endmodule

>>> design/hash_table_power_probe.sv
// Top level of the open-addressing key/value table with power-law probing.
// Each request transfer carries an insert, erase or find of a key of up to
// KEY_BYTES bytes and yields exactly one result transfer (status, value, slot).
// The front part hashes the key one byte per cycle and reduces the hash modulo
// the capacity one bit per cycle; an empty key or an unused opcode skips this.
// A two-entry queue feeds the back part, which walks the probe sequence, each
// probe being a slot memory read, then a compare, besides the states that take
// the job and deliver the result. The two parts overlap on consecutive items;
// throughput is set by the slower of the two. After reset the back part clears
// the slot store, during which no request is accepted; configuration writes
// are taken at any time and must only be issued while the block is idle.
module hash_table_power_probe
    import hpp_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BYTES   = 8,
    parameter int VALUE_BITS  = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // opcode[1:0], key_bytes[65:2], key_length[69:66],
                                    // value_in[101:70], zero fill above
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // status[1:0], value_out[33:2], slot_index[43:34],
                                    // zero fill above
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [10:0]  cfg_data
);

    localparam int KEYW = KEY_BYTES * 8;
    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CAPW = (CW > CFG_CAP_BITS) ? CW : CFG_CAP_BITS;
    localparam int JW   = 2 + KEYW + 4 + VALUE_BITS + IW;

    logic [CFG_CAP_BITS-1:0]   cap_reg;
    logic [CFG_POWER_BITS-1:0] power_reg;
    logic [CAPW-1:0]           cap_w;
    logic [CW-1:0]             cap_eff;

    logic                  front_in_valid, front_in_ready, clearing;
    logic                  fj_valid, fj_ready, bj_valid, bj_ready;
    logic [1:0]            fj_op;
    logic [KEYW-1:0]       fj_key;
    logic [3:0]            fj_len;
    logic [VALUE_BITS-1:0] fj_value;
    logic [IW-1:0]         fj_home;
    logic [JW-1:0]         fj_data, bj_data;
    logic [1:0]            res_status;
    logic [31:0]           res_value;
    logic [9:0]            res_slot;

    // Configuration: always ready, registers taken as written
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            power_reg <= POWER_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CAPACITY: cap_reg   <= cfg_data;
                REG_POWER:    power_reg <= cfg_data[CFG_POWER_BITS-1:0];
                default:      cap_reg   <= cap_reg;
            endcase
        end
    end

    // Zero capacity acts as one; anything beyond the store acts as its depth
    assign cap_w   = CAPW'(cap_reg);
    assign cap_eff = (cap_w == '0) ? CW'(1) :
                     ((cap_w > CAPW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cap_w));

    // Hold the request side while the slot store is being cleared
    assign front_in_valid = s_tvalid && !clearing;
    assign s_tready       = front_in_ready && !clearing;

    hpp_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cap        (cap_eff),
        .in_valid   (front_in_valid),
        .in_ready   (front_in_ready),
        .opcode     (s_tdata[1:0]),
        .key_bytes  (s_tdata[65:2]),
        .key_length (s_tdata[69:66]),
        .value_in   (s_tdata[101:70]),
        .job_valid  (fj_valid),
        .job_ready  (fj_ready),
        .job_op     (fj_op),
        .job_key    (fj_key),
        .job_len    (fj_len),
        .job_value  (fj_value),
        .job_home   (fj_home)
    );

    assign fj_data = {fj_home, fj_value, fj_len, fj_key, fj_op};

    hpp_fifo #(
        .WIDTH (JW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fj_valid),
        .in_ready  (fj_ready),
        .in_data   (fj_data),
        .out_valid (bj_valid),
        .out_ready (bj_ready),
        .out_data  (bj_data)
    );

    hpp_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cap        (cap_eff),
        .power      (power_reg),
        .job_valid  (bj_valid),
        .job_ready  (bj_ready),
        .job_op     (bj_data[1:0]),
        .job_key    (bj_data[2 +: KEYW]),
        .job_len    (bj_data[2 + KEYW +: 4]),
        .job_value  (bj_data[6 + KEYW +: VALUE_BITS]),
        .job_home   (bj_data[6 + KEYW + VALUE_BITS +: IW]),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_status (res_status),
        .res_value  (res_value),
        .res_slot   (res_slot),
        .clearing   (clearing)
    );

    assign m_tdata = {4'd0, res_slot, res_value, res_status};

    // No request transfer may complete during the clearing sweep
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !s_tready)
        else $error("request accepted during clearing sweep");

    // A failed result carries zero value and zero slot
    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_status != ST_OK) |-> (res_value == 32'd0 && res_slot == 10'd0))
        else $error("failed result with non-zero value or slot");

endmodule
